>>> hdl/lzcd_pkg.sv
// ----------------------------------------------------------------------------
// lzcd_pkg: shared types and constants of the zero-crossing edge detector
// Item formats, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package lzcd_pkg;

  localparam int unsigned LOG_SAMPLE_W        = 16;
  localparam int unsigned CFG_DATA_W          = 16;
  localparam int unsigned CFG_INDEX_W         = 2;
  localparam int unsigned THRESHOLD_W         = 16;
  localparam int unsigned FRAME_WIDTH_W       = 12;
  localparam int unsigned FRAME_HEIGHT_W      = 13;
  localparam int unsigned ROW_W               = 12;
  localparam int unsigned MAX_HEIGHT          = 4096;

  localparam int unsigned MAX_WIDTH_DEFAULT   = 2048;
  localparam int unsigned SAMPLE_BITS_DEFAULT = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_WIDTH     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_HEIGHT    = 2'd2;

  localparam logic [THRESHOLD_W-1:0]    THRESHOLD_RESET    = 16'd0;
  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 12'd640;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

  typedef struct packed {
    logic signed [LOG_SAMPLE_W-1:0] log_sample;
    logic                           frame_start;
  } lzcd_in_t;

  typedef struct packed {
    logic edge_mark;
    logic frame_end;
  } lzcd_out_t;

endpackage

>>> hdl/log_zero_crossing_detector_core.sv
// ----------------------------------------------------------------------------
// log_zero_crossing_detector_core: 3x3 zero-crossing edge marker
// Takes a raster stream of signed LoG responses, keeps two line buffers and
// a 3x3 window, and marks interior pixels where two or more opposite
// neighbor pairs change sign with a large enough step.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+------------------------------
//   in       | input     | in_valid_i/in_ready_o  | in_item_i  (lzcd_in_t)
//   out      | output    | out_valid_o/out_ready_i| out_item_o (lzcd_out_t)
//   cfg      | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One item is accepted per cycle while the work stage is empty or passes its
// item on; the line buffer is read at the accepting edge, the window and pair
// tests run while the item sits in the work stage, and the result is registered
// in the output register as the item leaves that stage.
// Reset clears the position counters and the window and loads the configuration reset values.
// When the output register is full and not taken, the work stage holds and
// input stalls; items that give no result pass through regardless.
module log_zero_crossing_detector_core
  import lzcd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = MAX_WIDTH_DEFAULT,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  lzcd_in_t               in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output lzcd_out_t              out_item_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WCMP_W = (COL_W + 1 > FRAME_WIDTH_W) ? COL_W + 1 : FRAME_WIDTH_W;
  localparam int unsigned CMP_W  = (SAMPLE_BITS + 1 > THRESHOLD_W) ? SAMPLE_BITS + 1
                                                                   : THRESHOLD_W;
  localparam int unsigned SB     = SAMPLE_BITS;

  typedef logic signed [SB-1:0] sample_t;

  function automatic logic pair_counts(input sample_t a, input sample_t b,
                                       input logic [THRESHOLD_W-1:0] thr);
    logic signed [SB:0] diff;
    logic        [SB:0] mag;
    logic               opp;
    opp  = (a[SB-1] && !b[SB-1] && (|b)) || (b[SB-1] && !a[SB-1] && (|a));
    diff = {a[SB-1], a} - {b[SB-1], b};
    mag  = diff[SB] ? (SB+1)'(-diff) : (SB+1)'(diff);
    return opp && (CMP_W'(mag) > CMP_W'(thr));
  endfunction

  // Configuration registers.
  logic [THRESHOLD_W-1:0]    thr_q;
  logic [FRAME_WIDTH_W-1:0]  fwidth_q;
  logic [FRAME_HEIGHT_W-1:0] fheight_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= THRESHOLD_RESET;
      fwidth_q  <= FRAME_WIDTH_RESET;
      fheight_q <= FRAME_HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IDX_THRESHOLD: thr_q     <= cfg_data_i[THRESHOLD_W-1:0];
        CFG_IDX_WIDTH:     fwidth_q  <= cfg_data_i[FRAME_WIDTH_W-1:0];
        CFG_IDX_HEIGHT:    fheight_q <= cfg_data_i[FRAME_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Geometry saturated to its legal range.
  logic [WCMP_W-1:0]         w_eff;
  logic [FRAME_HEIGHT_W-1:0] h_eff;

  always_comb begin
    if (WCMP_W'(fwidth_q) < WCMP_W'(3)) begin
      w_eff = WCMP_W'(3);
    end else if (WCMP_W'(fwidth_q) > WCMP_W'(MAX_WIDTH)) begin
      w_eff = WCMP_W'(MAX_WIDTH);
    end else begin
      w_eff = WCMP_W'(fwidth_q);
    end
    if (fheight_q < FRAME_HEIGHT_W'(3)) begin
      h_eff = FRAME_HEIGHT_W'(3);
    end else if (fheight_q > FRAME_HEIGHT_W'(MAX_HEIGHT)) begin
      h_eff = FRAME_HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_eff = fheight_q;
    end
  end

  // Stage 0: position tracking and line buffer read.
  logic [COL_W-1:0] col_q, col_cur;
  logic [ROW_W-1:0] row_q, row_cur;
  logic             last_col, last_row, in_accept;
  logic signed [31:0] sample_wide;
  sample_t          sample_in;

  assign in_accept   = in_valid_i && in_ready_o;
  assign col_cur     = in_item_i.frame_start ? '0 : col_q;
  assign row_cur     = in_item_i.frame_start ? '0 : row_q;
  assign last_col    = (WCMP_W'(col_cur) + WCMP_W'(1)) >= w_eff;
  assign last_row    = (FRAME_HEIGHT_W'(row_cur) + FRAME_HEIGHT_W'(1)) >= h_eff;
  assign sample_wide = 32'(in_item_i.log_sample);
  assign sample_in   = sample_wide[SB-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_accept) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_cur + ROW_W'(1);
      end else begin
        col_q <= col_cur + COL_W'(1);
        row_q <= row_cur;
      end
    end
  end

  // Stage 1 registers.
  logic             s1_valid_q, s1_emit_q, s1_last_q, s1_fwd_q;
  logic [COL_W-1:0] s1_col_q;
  sample_t          s1_sample_q;
  logic [2*SB-1:0]  rd_q, fwd_q, lines_cur;
  logic             s1_retire;
  sample_t          top, mid;

  // Each entry holds {row r-2, row r-1} for one column.
  logic [2*SB-1:0]  line_mem [MAX_WIDTH];

  assign lines_cur = s1_fwd_q ? fwd_q : rd_q;
  assign top       = lines_cur[2*SB-1:SB];
  assign mid       = lines_cur[SB-1:0];

  assign s1_retire  = s1_valid_q && (!s1_emit_q || !out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_retire;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rd_q        <= line_mem[col_cur];
      s1_col_q    <= col_cur;
      s1_sample_q <= sample_in;
      s1_emit_q   <= (col_cur >= COL_W'(2)) && (row_cur >= ROW_W'(2));
      s1_last_q   <= last_col && last_row;
      // A write to the same column at this edge is not seen by the read.
      fwd_q       <= {mid, s1_sample_q};
    end
    if (s1_retire) begin
      line_mem[s1_col_q] <= {mid, s1_sample_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_fwd_q   <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
        s1_fwd_q   <= s1_retire && (s1_col_q == col_cur);
      end else if (s1_retire) begin
        s1_valid_q <= 1'b0;
        s1_fwd_q   <= 1'b0;
      end
    end
  end

  // Window: columns c-2 (cells 0..2) and c-1 (cells 3..5), top to bottom.
  sample_t win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_retire) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top;
      win_q[4] <= mid;
      win_q[5] <= s1_sample_q;
    end
  end

  logic       p_diag, p_vert, p_anti, p_horiz;
  logic [2:0] pair_cnt;

  assign p_diag   = pair_counts(win_q[0], s1_sample_q, thr_q);
  assign p_vert   = pair_counts(win_q[3], win_q[5], thr_q);
  assign p_anti   = pair_counts(top, win_q[2], thr_q);
  assign p_horiz  = pair_counts(mid, win_q[1], thr_q);
  assign pair_cnt = {2'b00, p_diag} + {2'b00, p_vert} + {2'b00, p_anti} + {2'b00, p_horiz};

  // Output register.
  logic      out_valid_q;
  lzcd_out_t out_q;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_retire && s1_emit_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_retire && s1_emit_q) begin
      out_q.edge_mark <= pair_cnt >= 3'd2;
      out_q.frame_end <= s1_last_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (WCMP_W'(col_q) < WCMP_W'(MAX_WIDTH)))
    else $error("column counter beyond line buffer depth");

  a_fwd_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fwd_q |-> s1_valid_q)
    else $error("forwarding flag set without an item in the work stage");

  a_emit_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_retire && s1_emit_q) |=> out_valid_q)
    else $error("result item lost between work stage and output register");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted item did not reach the work stage");
`endif

endmodule

>>> verif/log_zero_crossing_checker.sv
// ----------------------------------------------------------------------------
// log_zero_crossing_checker: result predictor and comparator
// Watches the pixel, result and register channels of the zero-crossing edge
// detector, predicts the edge mark of every interior pixel and compares each
// accepted result, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module log_zero_crossing_checker
  import lzcd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = MAX_WIDTH_DEFAULT,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  lzcd_in_t               in_item_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  lzcd_out_t              out_item_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     checked_o,
  output int                     edges_o,
  output int                     frame_ends_o
);

  localparam int REPORT_LIMIT = 10;

  logic [THRESHOLD_W-1:0]         threshold_q;
  logic [FRAME_WIDTH_W-1:0]       width_q;
  logic [FRAME_HEIGHT_W-1:0]      height_q;
  logic signed [LOG_SAMPLE_W-1:0] row_two_up [MAX_WIDTH];
  logic signed [LOG_SAMPLE_W-1:0] row_one_up [MAX_WIDTH];
  // Columns c-2 (0..2) and c-1 (3..5) of rows r-2, r-1 and r.
  logic signed [LOG_SAMPLE_W-1:0] window [6];
  int unsigned                    col_pos;
  int unsigned                    row_pos;
  lzcd_out_t                      expected_marks [$];
  lzcd_out_t                      head_mark;

  // A pair counts on a strict sign change whose step exceeds the threshold.
  function automatic int crosses(input logic signed [LOG_SAMPLE_W-1:0] a,
                                 input logic signed [LOG_SAMPLE_W-1:0] b);
    int step;
    if (!((a < 0 && b > 0) || (a > 0 && b < 0))) return 0;
    step = int'(a) - int'(b);
    if (step < 0) step = -step;
    return (step > int'(threshold_q)) ? 1 : 0;
  endfunction

  task automatic predict_pixel(input lzcd_in_t item);
    int unsigned                    wid;
    int unsigned                    hgt;
    int unsigned                    c;
    int unsigned                    r;
    int unsigned                    idx;
    int                             hits;
    logic signed [LOG_SAMPLE_W-1:0] s;
    logic signed [LOG_SAMPLE_W-1:0] above2;
    logic signed [LOG_SAMPLE_W-1:0] above1;
    lzcd_out_t                      mark;
    wid = (width_q < 3) ? 3 : (width_q > MAX_WIDTH) ? MAX_WIDTH : width_q;
    hgt = (height_q < 3) ? 3 : (height_q > MAX_HEIGHT) ? MAX_HEIGHT : height_q;
    if (item.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    s = $signed(item.log_sample << (LOG_SAMPLE_W - SAMPLE_BITS))
        >>> (LOG_SAMPLE_W - SAMPLE_BITS);
    idx = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
    above2 = row_two_up[idx];
    above1 = row_one_up[idx];
    row_two_up[idx] = above1;
    row_one_up[idx] = s;
    if (c >= 2 && r >= 2) begin
      hits = crosses(window[0], s) + crosses(window[3], window[5])
           + crosses(above2, window[2]) + crosses(above1, window[1]);
      mark.edge_mark = (hits >= 2);
      mark.frame_end = (c + 1 >= wid && r + 1 >= hgt);
      expected_marks.push_back(mark);
    end
    window[0] = window[3];
    window[1] = window[4];
    window[2] = window[5];
    window[3] = above2;
    window[4] = above1;
    window[5] = s;
    if (c + 1 >= wid) begin
      col_pos = 0;
      row_pos = (r + 1 >= hgt) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q = THRESHOLD_RESET;
      width_q = FRAME_WIDTH_RESET;
      height_q = FRAME_HEIGHT_RESET;
      foreach (row_two_up[k]) begin
        row_two_up[k] = '0;
        row_one_up[k] = '0;
      end
      foreach (window[k]) window[k] = '0;
      col_pos = 0;
      row_pos = 0;
      expected_marks.delete();
      fail_count_o = 0;
      checked_o = 0;
      edges_o = 0;
      frame_ends_o = 0;
    end else begin
      // Results leave before the item of this edge is predicted, so a stray
      // result can never consume a prediction made in the same cycle.
      if (out_valid_i && out_ready_i) begin
        if (expected_marks.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= REPORT_LIMIT) begin
            $display("%0t: result edge_mark=%0b frame_end=%0b with no pixel pending",
                     $time, out_item_i.edge_mark, out_item_i.frame_end);
          end
        end else begin
          head_mark = expected_marks.pop_front();
          checked_o++;
          edges_o += head_mark.edge_mark;
          frame_ends_o += head_mark.frame_end;
          if (out_item_i.edge_mark !== head_mark.edge_mark ||
              out_item_i.frame_end !== head_mark.frame_end) begin
            fail_count_o++;
            if (fail_count_o <= REPORT_LIMIT) begin
              $display("%0t: result %0d expected edge_mark=%0b frame_end=%0b, got %0b %0b",
                       $time, checked_o, head_mark.edge_mark, head_mark.frame_end,
                       out_item_i.edge_mark, out_item_i.frame_end);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_IDX_THRESHOLD: threshold_q = cfg_data_i[THRESHOLD_W-1:0];
          CFG_IDX_WIDTH:     width_q = cfg_data_i[FRAME_WIDTH_W-1:0];
          CFG_IDX_HEIGHT:    height_q = cfg_data_i[FRAME_HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_pixel(in_item_i);
    end
    pending_o = expected_marks.size();
  end

endmodule

>>> verif/log_zero_crossing_detector_core_test.sv
// ----------------------------------------------------------------------------
// log_zero_crossing_detector_core_test: stimulus and verdict
// Drives pixel streams and register settings into the edge detector with
// random gaps and output stalls: a directed step-edge frame at the threshold
// limits, degenerate and oversized frame sizes that must clamp, geometry
// changes mid-frame, then randomly configured frames with restarts and pauses.
// ----------------------------------------------------------------------------
module log_zero_crossing_detector_core_test;
  import lzcd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned RANDOM_ITEMS  = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam logic [CFG_INDEX_W-1:0]  CFG_IDX_SPARE = 2'd3;
  localparam logic [LOG_SAMPLE_W-1:0] POS_FULL = 16'h7FFF;
  localparam logic [LOG_SAMPLE_W-1:0] NEG_FULL = 16'h8000;
  // Vertical step from full negative to full positive, one zero in a corner.
  localparam logic [LOG_SAMPLE_W-1:0] STEP_FRAME [12] = '{
    NEG_FULL, NEG_FULL, POS_FULL, POS_FULL,
    NEG_FULL, NEG_FULL, POS_FULL, POS_FULL,
    NEG_FULL, NEG_FULL, POS_FULL, 16'h0000
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  lzcd_in_t               in_item = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  lzcd_out_t              out_item;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int          fail_count;
  int          pending;
  int          checked;
  int          edges;
  int          frame_ends;
  bit          quiet = 1'b0;
  int          stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned sent_items = 0;
  int unsigned random_items = 0;
  int unsigned settings_used = 0;
  int unsigned frame_w = FRAME_WIDTH_RESET;
  int unsigned frame_h = FRAME_HEIGHT_RESET;

  always #5 clk_i = ~clk_i;

  log_zero_crossing_detector_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  log_zero_crossing_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .edges_o      (edges),
    .frame_ends_o (frame_ends)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Mostly short pauses, now and then a long one.
  function automatic int pause_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
  endfunction

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      stall_left = pause_len();
    end
    out_ready <= (stall_left == 0);
  end

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    return (v < 3) ? 3 : (v > hi) ? hi : v;
  endfunction

  function automatic logic [LOG_SAMPLE_W-1:0] pick_sample();
    logic [LOG_SAMPLE_W-1:0] mag;
    mag = LOG_SAMPLE_W'($urandom_range(1, 64));
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom_range(0, 1) ? POS_FULL : NEG_FULL;
      2, 3, 4: return $urandom_range(0, 1) ? mag : -mag;
      default: return LOG_SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic logic [THRESHOLD_W-1:0] pick_threshold();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return THRESHOLD_W'($urandom_range(0, 64));
      3:       return THRESHOLD_W'($urandom_range(0, 200));
      default: return THRESHOLD_W'($urandom());
    endcase
  endfunction

  // Values below three exercise the lower saturation of the frame size.
  function automatic int unsigned pick_dim(input int unsigned common_hi,
                                           input int unsigned rare_hi);
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 2);
      1, 2:    return $urandom_range(common_hi + 1, rare_hi);
      default: return $urandom_range(3, common_hi);
    endcase
  endfunction

  // Unused upper data bits and the spare register index carry random junk.
  task automatic program_regs(input logic [THRESHOLD_W-1:0]    thr,
                              input logic [FRAME_WIDTH_W-1:0]  wid,
                              input logic [FRAME_HEIGHT_W-1:0] hgt);
    logic [CFG_INDEX_W-1:0] idx [4];
    logic [CFG_DATA_W-1:0]  val [4];
    int                     n;
    int                     k;
    idx = '{CFG_IDX_THRESHOLD, CFG_IDX_WIDTH, CFG_IDX_HEIGHT, CFG_IDX_SPARE};
    val = '{thr, {4'($urandom()), wid}, {3'($urandom()), hgt}, 16'($urandom())};
    n = ($urandom_range(0, 3) == 0) ? 4 : 3;
    for (k = 0; k < n; k++) begin
      cfg_index <= idx[k];
      cfg_data <= val[k];
      cfg_valid <= 1'b1;
      do @(posedge clk_i); while (!cfg_ready);
      @(negedge clk_i);
    end
    cfg_valid <= 1'b0;
    frame_w = clamp_dim(wid, MAX_WIDTH_DEFAULT);
    frame_h = clamp_dim(hgt, MAX_HEIGHT);
    settings_used++;
  endtask

  // Entered and left at a falling edge; valid stays high into the next item.
  task automatic push_pixel(input logic [LOG_SAMPLE_W-1:0] sample, input logic start);
    int gap;
    gap = (quiet || $urandom_range(0, 9) < 6) ? 0 : pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item <= '{log_sample: sample, frame_start: start};
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    sent_items++;
  endtask

  // Hold off until every predicted result is out, then let the pipeline
  // flush pixels that produce no result.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic stream_pixels(input int unsigned count, input bit restart, input bit noisy);
    int unsigned i;
    logic        start;
    for (i = 0; i < count; i++) begin
      start = (i == 0) && restart;
      if (noisy && i > 0 && $urandom_range(0, 299) == 0) start = 1'b1;
      if (noisy && i > 0 && $urandom_range(0, 199) == 0) wait_idle();
      push_pixel(pick_sample(), start);
    end
  endtask

  initial begin
    int unsigned count;
    int          k;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // The step edge clears the largest threshold that still lets it count,
    // then the same frame fails the top threshold and wraps without a start.
    program_regs(16'd65534, 12'd4, 13'd3);
    for (k = 0; k < 12; k++) push_pixel(STEP_FRAME[k], k == 0);
    wait_idle();
    program_regs(16'd65535, 12'd4, 13'd3);
    for (k = 0; k < 12; k++) push_pixel(STEP_FRAME[k], 1'b0);
    wait_idle();

    program_regs(16'd0, 12'd0, 13'd0);
    stream_pixels(2 * frame_w * frame_h, 1'b1, 1'b0);
    wait_idle();

    // Shrink the width and height mid-frame, then let the height grow.
    program_regs(16'd100, 12'd10, 13'd8);
    stream_pixels(35, 1'b1, 1'b0);
    wait_idle();
    program_regs(16'd100, 12'd4, 13'd5);
    stream_pixels(25, 1'b0, 1'b0);
    wait_idle();
    program_regs(16'd100, 12'd4, 13'd9);
    stream_pixels(40, 1'b0, 1'b0);
    wait_idle();

    // Oversized settings clamp high at full rate: a long first row must not
    // wrap early, then a narrow frame must not end early at a huge height.
    quiet = 1'b1;
    program_regs(pick_threshold(), '1, 13'd3);
    stream_pixels(30, 1'b1, 1'b0);
    wait_idle();
    program_regs(pick_threshold(), 12'd4, 13'd3);
    stream_pixels(20, 1'b0, 1'b0);
    wait_idle();
    program_regs(pick_threshold(), 12'd4, '1);
    stream_pixels(80, 1'b1, 1'b0);
    wait_idle();

    while (random_items < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 4) == 0);
      program_regs(pick_threshold(), FRAME_WIDTH_W'(pick_dim(10, 40)),
                   FRAME_HEIGHT_W'(pick_dim(6, 12)));
      count = $urandom_range(1, 3) * frame_w * frame_h;
      if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
      stream_pixels(count, 1'b1, 1'b1);
      random_items += count;
      wait_idle();
    end

    repeat (8) @(negedge clk_i);
    $display("Sent %0d pixels (%0d random) under %0d register settings.",
             sent_items, random_items, settings_used);
    $display("Checked %0d results: %0d edge pixels and %0d frame ends.",
             checked, edges, frame_ends);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/lzcd_pkg.sv
hdl/log_zero_crossing_detector_core.sv
verif/log_zero_crossing_checker.sv
verif/log_zero_crossing_detector_core_test.sv
